// ===== hdl/bdr_pkg.sv =====
// Shared constants and codes for the block disk register port.
`timescale 1ns / 1ps

package bdr_pkg;

  localparam int unsigned DATA_W          = 8;
  localparam int unsigned BLOCK_BYTES     = 256;
  localparam int unsigned OFF_W           = $clog2(BLOCK_BYTES);
  localparam int unsigned BLOCK_NUM_W     = 16;
  localparam int unsigned BLOCK_COUNT_DEF = 1024;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register indexes.
  localparam logic [7:0] REG_BLK_HI = 8'd0;
  localparam logic [7:0] REG_BLK_LO = 8'd1;
  localparam logic [7:0] REG_OFFSET = 8'd2;
  localparam logic [7:0] REG_DATA   = 8'd3;
  localparam logic [7:0] REG_STATUS = 8'd4;
  localparam logic [7:0] REG_CNT_HI = 8'd5;
  localparam logic [7:0] REG_CNT_LO = 8'd6;

  // Command codes written to the status register.
  localparam logic [DATA_W-1:0] CMD_LOAD  = 8'd1;
  localparam logic [DATA_W-1:0] CMD_STORE = 8'd2;
  localparam logic [DATA_W-1:0] CMD_CLEAR = 8'd3;

  localparam logic [DATA_W-1:0] READ_UNKNOWN = 8'hFF;

endpackage

// ===== hdl/bdr_if.sv =====
// Valid/ready channel interfaces for the register access and read result beats.
`timescale 1ns / 1ps

interface bdr_in_if import bdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [7:0]        reg_index;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output op, output reg_index, output write_data, input ready);
  modport sink   (input valid, input op, input reg_index, input write_data, output ready);
endinterface

interface bdr_out_if import bdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

// ===== hdl/bdr_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/block_disk_register_port.sv =====
// Byte-wide register port to a block disk held in on-chip memory. After reset the block
// sweeps the disk memory to zero, one byte a cycle, and takes no access until that pass
// is done. A read of the data port then waits on the registered read of the buffer
// memory. A load or store command walks the block through the single read port of the
// source memory, one byte a cycle, and holds the port until the whole block is copied.
// A read result sits in a single output register. While it waits to be collected no
// new access is taken; the next one can be taken in the cycle the result is collected
// at the earliest.
`timescale 1ns / 1ps

module block_disk_register_port import bdr_pkg::*; #(
  parameter int unsigned BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdr_in_if.sink    in_i,
  bdr_out_if.source out_o
);

  localparam int unsigned DISK_DEPTH = BLOCK_COUNT * BLOCK_BYTES;
  localparam int unsigned DISK_AW    = $clog2(DISK_DEPTH);
  localparam int unsigned CNT_W      = OFF_W + 1;
  localparam logic [BLOCK_NUM_W-1:0] BLK_CNT = BLOCK_NUM_W'(BLOCK_COUNT);
  localparam logic [DISK_AW-1:0]     CLR_LAST = DISK_AW'(DISK_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BUF_RD,
    ST_LOAD,
    ST_STORE
  } state_e;

  state_e st_q, st_d;
  logic [BLOCK_NUM_W-1:0] blk_q, blk_d;
  logic [OFF_W-1:0]       off_q, off_d;
  logic                   err_q, err_d;
  logic [BLOCK_BYTES-1:0] vld_q, vld_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [DISK_AW-1:0]     clr_q, clr_d;
  logic                   out_vld_q, out_vld_d;
  logic [DATA_W-1:0]      out_data_q, out_data_d;

  logic              in_acc;
  logic              blk_oor;
  logic [OFF_W-1:0]  cur_off, prev_off;

  logic              buf_we, buf_re;
  logic [OFF_W-1:0]  buf_waddr, buf_raddr;
  logic [DATA_W-1:0] buf_wdata, buf_rdata;

  logic               disk_we, disk_re;
  logic [DISK_AW-1:0] disk_waddr, disk_raddr;
  logic [DATA_W-1:0]  disk_wdata, disk_rdata;

  assign in_i.ready    = (st_q == ST_IDLE) && (!out_vld_q || out_o.ready);
  assign in_acc        = in_i.valid && in_i.ready;
  assign out_o.valid   = out_vld_q;
  assign out_o.read_data = out_data_q;

  assign blk_oor  = (blk_q >= BLK_CNT);
  assign cur_off  = cnt_q[OFF_W-1:0];
  assign prev_off = OFF_W'(cnt_q - CNT_W'(1));

  // The sequencer serializes every access, so a buffer or disk entry is never read and
  // written in the same cycle. Buffer entries without a valid bit read as zero.
  always_comb begin
    st_d       = st_q;
    blk_d      = blk_q;
    off_d      = off_q;
    err_d      = err_q;
    vld_d      = vld_q;
    rd_vld_d   = rd_vld_q;
    cnt_d      = cnt_q;
    clr_d      = clr_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_data_d = out_data_q;

    buf_we     = 1'b0;
    buf_waddr  = off_q;
    buf_wdata  = in_i.write_data;
    buf_re     = 1'b0;
    buf_raddr  = off_q;
    disk_we    = 1'b0;
    disk_waddr = clr_q;
    disk_wdata = '0;
    disk_re    = 1'b0;
    disk_raddr = DISK_AW'({blk_q, cur_off});

    unique case (st_q)
      ST_INIT: begin
        disk_we = 1'b1;
        clr_d   = clr_q + DISK_AW'(1);
        if (clr_q == CLR_LAST) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.op == OP_READ) begin
            out_vld_d = 1'b1;
            case (in_i.reg_index)
              REG_BLK_HI: out_data_d = blk_q[15:8];
              REG_BLK_LO: out_data_d = blk_q[7:0];
              REG_OFFSET: out_data_d = off_q;
              REG_DATA: begin
                // The result follows once the buffer read data is back.
                out_vld_d = 1'b0;
                buf_re    = 1'b1;
                rd_vld_d  = vld_q[off_q];
                off_d     = off_q + OFF_W'(1);
                st_d      = ST_BUF_RD;
              end
              REG_STATUS: out_data_d = {{(DATA_W-1){1'b0}}, err_q};
              REG_CNT_HI: out_data_d = BLK_CNT[15:8];
              REG_CNT_LO: out_data_d = BLK_CNT[7:0];
              default:    out_data_d = READ_UNKNOWN;
            endcase
          end else begin
            case (in_i.reg_index)
              REG_BLK_HI: blk_d = {in_i.write_data, blk_q[7:0]};
              REG_BLK_LO: blk_d = {blk_q[15:8], in_i.write_data};
              REG_OFFSET: off_d = in_i.write_data;
              REG_DATA: begin
                buf_we       = 1'b1;
                vld_d[off_q] = 1'b1;
                off_d        = off_q + OFF_W'(1);
              end
              REG_STATUS: begin
                if (in_i.write_data == CMD_LOAD || in_i.write_data == CMD_STORE) begin
                  err_d = blk_oor;
                  cnt_d = '0;
                  if (!blk_oor) begin
                    st_d = (in_i.write_data == CMD_LOAD) ? ST_LOAD : ST_STORE;
                  end
                end else if (in_i.write_data == CMD_CLEAR) begin
                  vld_d = '0;
                  err_d = 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_BUF_RD: begin
        out_vld_d  = 1'b1;
        out_data_d = rd_vld_q ? buf_rdata : '0;
        st_d       = ST_IDLE;
      end
      ST_LOAD: begin
        // Disk reads run one byte ahead of the buffer writes.
        disk_re = !cnt_q[OFF_W];
        if (cnt_q != '0) begin
          buf_we          = 1'b1;
          buf_waddr       = prev_off;
          buf_wdata       = disk_rdata;
          vld_d[prev_off] = 1'b1;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q[OFF_W]) begin
          st_d = ST_IDLE;
        end
      end
      ST_STORE: begin
        if (!cnt_q[OFF_W]) begin
          buf_re    = 1'b1;
          buf_raddr = cur_off;
          rd_vld_d  = vld_q[cur_off];
        end
        if (cnt_q != '0) begin
          disk_we    = 1'b1;
          disk_waddr = DISK_AW'({blk_q, prev_off});
          disk_wdata = rd_vld_q ? buf_rdata : '0;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q[OFF_W]) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_INIT;
      blk_q      <= '0;
      off_q      <= '0;
      err_q      <= 1'b0;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      cnt_q      <= '0;
      clr_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      st_q       <= st_d;
      blk_q      <= blk_d;
      off_q      <= off_d;
      err_q      <= err_d;
      vld_q      <= vld_d;
      rd_vld_q   <= rd_vld_d;
      cnt_q      <= cnt_d;
      clr_q      <= clr_d;
      out_vld_q  <= out_vld_d;
      out_data_q <= out_data_d;
    end
  end

  bdr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BLOCK_BYTES)
  ) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  bdr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DISK_DEPTH)
  ) u_disk_ram (
    .clk_i   (clk_i),
    .we_i    (disk_we),
    .waddr_i (disk_waddr),
    .wdata_i (disk_wdata),
    .re_i    (disk_re),
    .raddr_i (disk_raddr),
    .rdata_o (disk_rdata)
  );

`ifndef SYNTHESIS
  a_buf_rd_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_BUF_RD |-> $past(in_acc))
    else $error("buffer read result state entered without an accepted beat");

  a_copy_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LOAD || st_q == ST_STORE) |-> !blk_oor)
    else $error("block copy running on an out-of-range block");

  a_copy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LOAD || st_q == ST_STORE) && cnt_q[OFF_W] |=> st_q == ST_IDLE)
    else $error("block copy did not finish after the last byte");

  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_INIT |-> !in_i.ready && !out_vld_q)
    else $error("access possible while the disk is being cleared");

  a_disk_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disk_re |-> !disk_we && st_q == ST_LOAD)
    else $error("disk memory read outside a load");
`endif

endmodule
